// ----- design/orf_pkg.sv -----
package orf_pkg;

	// Opcodes
	localparam logic [7:0] OPC_RETURN    = 8'h6a;
	localparam logic [7:0] OPC_PUSHDATA1 = 8'h4c;
	localparam logic [7:0] OPC_PUSHDATA2 = 8'h4d;
	localparam logic [7:0] OPC_PUSHDATA4 = 8'h4e;
	localparam logic [7:0] OPC_1NEGATE   = 8'h4f;
	localparam logic [7:0] OPC_RESERVED  = 8'h50;
	localparam logic [7:0] OPC_16        = 8'h60;
	localparam logic [7:0] DIRECT_MAX    = 8'd75;
	localparam logic [7:0] MAX_PUSH_RESET = 8'd80;

	// ASCII
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] HEX_ALPHA_BASE = 8'h57; // 'a' - 10

	localparam logic [7:0] OP_TEXT [9] = '{8'h4f, 8'h50, 8'h5f, 8'h52, 8'h45,
		8'h54, 8'h55, 8'h52, 8'h4e};

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int IDX_W       = 4;

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_OPCODE,
		PH_LEN,
		PH_DATA,
		PH_DONE
	} phase_t;

	// Character groups the back end knows how to spell
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_OPRET,   // name of the return opcode, nine characters
		CMD_SP0,     // " 0"
		CMD_SP0X,    // " 0x"
		CMD_SP,      // " "
		CMD_SPNEG1,  // " -1"
		CMD_SPNUM,   // " " and 1..16
		CMD_ZEROX,   // "0x"
		CMD_HEX      // two hex digits
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
		logic       fin;   // script ends after this group
		logic       ok;    // script accepted (valid with fin)
	} cmd_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return CH_ZERO + {4'b0, nib};
		end
		return HEX_ALPHA_BASE + {4'b0, nib};
	endfunction

	function automatic logic [IDX_W-1:0] cmd_len(input cmd_kind_t kind, input logic [7:0] data);
		logic [7:0] num;
		logic [IDX_W-1:0] len;
		num = data - OPC_RESERVED;
		unique case (kind)
			CMD_OPRET:  len = IDX_W'(9);
			CMD_SP0:    len = IDX_W'(2);
			CMD_SP0X:   len = IDX_W'(3);
			CMD_SP:     len = IDX_W'(1);
			CMD_SPNEG1: len = IDX_W'(3);
			CMD_SPNUM:  len = (num >= 8'd10) ? IDX_W'(3) : IDX_W'(2);
			CMD_ZEROX:  len = IDX_W'(2);
			CMD_HEX:    len = IDX_W'(2);
			default:    len = '0;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] cmd_char(input cmd_kind_t kind, input logic [7:0] data,
		input logic [IDX_W-1:0] idx);
		logic [7:0] num;
		logic [7:0] c;
		num = data - OPC_RESERVED;
		unique case (kind)
			CMD_OPRET:  c = OP_TEXT[idx];
			CMD_SP0:    c = (idx == '0) ? CH_SPACE : CH_ZERO;
			CMD_SP0X: begin
				if (idx == '0) c = CH_SPACE;
				else if (idx == IDX_W'(1)) c = CH_ZERO;
				else c = CH_X;
			end
			CMD_SP:     c = CH_SPACE;
			CMD_SPNEG1: begin
				if (idx == '0) c = CH_SPACE;
				else if (idx == IDX_W'(1)) c = CH_MINUS;
				else c = CH_ONE;
			end
			CMD_SPNUM: begin
				if (idx == '0) c = CH_SPACE;
				else if (num < 8'd10) c = CH_ZERO + num;
				else if (idx == IDX_W'(1)) c = CH_ONE;
				else c = CH_ZERO + (num - 8'd10);
			end
			CMD_ZEROX:  c = (idx == '0) ? CH_ZERO : CH_X;
			CMD_HEX:    c = (idx == '0) ? hex_char(data[7:4]) : hex_char(data[3:0]);
			default:    c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage

// ----- design/op_return_script_formatter.sv -----
// Channel   Direction  Handshake           Fields
// input     in         push / full         script_byte[7:0], last
// result    out        empty / pop         character[7:0], status, text_length[7:0], last_res
// config    in         cfg_write           cfg_data[7:0] (max_push_length, reset 80)
//
// Each accepted byte is classified in the cycle it is taken and becomes at most
// one command word in a 4-deep queue; the back end spells one character per
// cycle unless pop stalls it. A data byte gives two hex digits, the return opcode
// nine characters, the end word one more; the back end's single port sets throughput.
// Reset clears script state, queue and output register; the limit returns to 80.
// full rises when the queue holds 4 words; the output register reloads in the
// same cycle it is popped, so a stalled consumer only backs up the queue.
module op_return_script_formatter (
	input  logic       clk,
	input  logic       arst_n,
	// input queue side
	input  logic       push,
	output logic       full,
	input  logic [7:0] script_byte,
	input  logic       last,
	// result queue side
	output logic       empty,
	input  logic       pop,
	output logic [7:0] character,
	output logic       status,
	output logic [7:0] text_length,
	output logic       last_res,
	// max_push_length register
	input  logic       cfg_write,
	input  logic [7:0] cfg_data
);

	logic [7:0]    max_push_length_q;
	logic          take, q_wr, q_rd, q_full, q_empty;
	orf_pkg::cmd_t q_wdata, q_rdata;

	// an input word is taken whenever it is offered and the queue has room
	assign full = q_full;
	assign take = push && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_push_length_q <= orf_pkg::MAX_PUSH_RESET;
		else if (cfg_write) max_push_length_q <= cfg_data;
	end

	// front: tracks phase, push length and reject, emits at most one command per byte
	orf_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.max_push_length (max_push_length_q),
		.take            (take),
		.script_byte     (script_byte),
		.last            (last),
		.wr              (q_wr),
		.cmd             (q_wdata)
	);

	// decoupling queue between classification and character output
	orf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back: expands commands into characters, counts text, builds the end word
	orf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_rdata),
		.head_valid  (!q_empty),
		.rd          (q_rd),
		.pop         (pop),
		.empty       (empty),
		.character   (character),
		.status      (status),
		.text_length (text_length),
		.last_res    (last_res)
	);

	// character words carry no status or length and never a NUL
	a_char_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last_res) |-> (status == 1'b0 && text_length == 8'd0 && character != 8'd0))
		else $error("character word with end fields set");

	// end word: NUL, and exactly one of rejected or a nonzero length
	a_end_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_res) |-> (character == 8'd0 && (status != (text_length != 8'd0))))
		else $error("malformed end word");

	// the queue is never read while empty nor written while full
	a_queue_ok: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_rd && q_empty) && !(q_wr && q_full))
		else $error("queue overrun or underrun");

endmodule

// ----- design/orf_front.sv -----
module orf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       max_push_length,
	input  logic             take,
	input  logic [7:0]       script_byte,
	input  logic             last,
	output logic             wr,
	output orf_pkg::cmd_t    cmd
);

	orf_pkg::phase_t phase_q, phase_d;
	logic            rejected_q, rejected_d;
	logic [7:0]      byte_count_q, byte_count_d;
	logic [7:0]      expected_length_q, expected_length_d;
	logic [7:0]      bc_inc;
	logic            bad_op;
	orf_pkg::cmd_kind_t kind;

	assign bc_inc = byte_count_q + 8'd1;
	assign bad_op = (script_byte > orf_pkg::OPC_16) || (script_byte == orf_pkg::OPC_RESERVED) ||
		(script_byte == orf_pkg::OPC_PUSHDATA2) || (script_byte == orf_pkg::OPC_PUSHDATA4);

	// next state
	always_comb begin
		phase_d           = phase_q;
		rejected_d        = rejected_q;
		byte_count_d      = byte_count_q;
		expected_length_d = expected_length_q;
		if (!rejected_q) begin
			unique case (phase_q)
				orf_pkg::PH_FIRST: begin
					if (script_byte == orf_pkg::OPC_RETURN) phase_d = orf_pkg::PH_OPCODE;
					else rejected_d = 1'b1;
				end
				orf_pkg::PH_OPCODE: begin
					priority if (bad_op) begin
						rejected_d = 1'b1;
					end else if (script_byte == 8'd0) begin
						phase_d = orf_pkg::PH_DONE;
					end else if (script_byte <= orf_pkg::DIRECT_MAX) begin
						expected_length_d = script_byte;
						byte_count_d      = '0;
						phase_d           = orf_pkg::PH_DATA;
					end else if (script_byte == orf_pkg::OPC_PUSHDATA1) begin
						phase_d = orf_pkg::PH_LEN;
					end else begin
						phase_d = orf_pkg::PH_DONE;
					end
				end
				orf_pkg::PH_LEN: begin
					priority if (script_byte > max_push_length) begin
						rejected_d = 1'b1;
					end else if (script_byte == 8'd0) begin
						expected_length_d = '0;
						phase_d           = orf_pkg::PH_DONE;
					end else begin
						expected_length_d = script_byte;
						byte_count_d      = '0;
						phase_d           = orf_pkg::PH_DATA;
					end
				end
				orf_pkg::PH_DATA: begin
					byte_count_d = bc_inc;
					if (bc_inc >= expected_length_q) phase_d = orf_pkg::PH_DONE;
				end
				default: rejected_d = 1'b1; // byte after a complete push
			endcase
		end
	end

	// outputs
	always_comb begin
		kind = orf_pkg::CMD_NONE;
		if (!rejected_q) begin
			unique case (phase_q)
				orf_pkg::PH_FIRST: begin
					if (script_byte == orf_pkg::OPC_RETURN) kind = orf_pkg::CMD_OPRET;
				end
				orf_pkg::PH_OPCODE: begin
					priority if (bad_op) kind = orf_pkg::CMD_NONE;
					else if (script_byte == 8'd0) kind = orf_pkg::CMD_SP0;
					else if (script_byte <= orf_pkg::DIRECT_MAX) kind = orf_pkg::CMD_SP0X;
					else if (script_byte == orf_pkg::OPC_PUSHDATA1) kind = orf_pkg::CMD_SP;
					else if (script_byte == orf_pkg::OPC_1NEGATE) kind = orf_pkg::CMD_SPNEG1;
					else kind = orf_pkg::CMD_SPNUM;
				end
				orf_pkg::PH_LEN: begin
					if (script_byte <= max_push_length && script_byte != 8'd0)
						kind = orf_pkg::CMD_ZEROX;
				end
				orf_pkg::PH_DATA: kind = orf_pkg::CMD_HEX;
				default: kind = orf_pkg::CMD_NONE;
			endcase
		end
		cmd.kind = kind;
		cmd.data = script_byte;
		cmd.fin  = last;
		cmd.ok   = !rejected_d && (phase_d == orf_pkg::PH_OPCODE || phase_d == orf_pkg::PH_DONE);
		wr       = take && (kind != orf_pkg::CMD_NONE || last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= orf_pkg::PH_FIRST;
			rejected_q        <= 1'b0;
			byte_count_q      <= '0;
			expected_length_q <= '0;
		end else if (take) begin
			if (last) begin
				phase_q           <= orf_pkg::PH_FIRST;
				rejected_q        <= 1'b0;
				byte_count_q      <= '0;
				expected_length_q <= '0;
			end else begin
				phase_q           <= phase_d;
				rejected_q        <= rejected_d;
				byte_count_q      <= byte_count_d;
				expected_length_q <= expected_length_d;
			end
		end
	end

endmodule

// ----- design/orf_queue.sv -----
module orf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  orf_pkg::cmd_t wdata,
	input  logic          rd,
	output orf_pkg::cmd_t rdata,
	output logic          full,
	output logic          empty
);

	orf_pkg::cmd_t                 mem_q [orf_pkg::QUEUE_DEPTH];
	logic [orf_pkg::QUEUE_AW-1:0] wp_q, rp_q;
	logic [orf_pkg::QUEUE_AW:0]   cnt_q;
	logic                          do_wr, do_rd;

	assign full  = (cnt_q == (orf_pkg::QUEUE_AW+1)'(orf_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + 1'b1;
			if (do_rd) rp_q <= rp_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- design/orf_back.sv -----
module orf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  orf_pkg::cmd_t head,
	input  logic          head_valid,
	output logic          rd,
	input  logic          pop,
	output logic          empty,
	output logic [7:0]    character,
	output logic          status,
	output logic [7:0]    text_length,
	output logic          last_res
);

	logic [orf_pkg::IDX_W-1:0] idx_q, len;
	logic [7:0]                text_count_q, end_len, ch;
	logic                      out_valid_q, load, in_chars, group_end;

	assign len       = orf_pkg::cmd_len(head.kind, head.data);
	assign ch        = orf_pkg::cmd_char(head.kind, head.data, idx_q);
	assign in_chars  = idx_q < len;
	assign group_end = (idx_q == len - 1'b1) && !head.fin;
	assign load      = head_valid && (!out_valid_q || pop);
	assign rd        = load && (!in_chars || group_end);
	assign end_len   = (text_count_q == 8'hff) ? 8'hff : text_count_q + 8'd1;
	assign empty     = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			text_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (in_chars) begin
					idx_q <= group_end ? '0 : idx_q + 1'b1;
					if (text_count_q != 8'hff) text_count_q <= text_count_q + 8'd1;
				end else begin
					idx_q        <= '0;
					text_count_q <= '0;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word, no reset needed
	always_ff @(posedge clk) begin
		if (load) begin
			character   <= in_chars ? ch : orf_pkg::CH_NUL;
			status      <= !in_chars && !head.ok;
			text_length <= (!in_chars && head.ok) ? end_len : 8'd0;
			last_res    <= !in_chars;
		end
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	// push-only opcode that has no name in the package
	localparam logic [7:0] OPC_0 = 8'h00;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_WORDS = 30;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] script_byte = 8'h00;
	logic       last = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] character;
	logic       status;
	logic [7:0] text_length;
	logic       last_res;
	logic       cfg_write = 1'b0;
	logic [7:0] cfg_data = 8'h00;

	op_return_script_formatter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.script_byte (script_byte),
		.last        (last),
		.empty       (empty),
		.pop         (pop),
		.character   (character),
		.status      (status),
		.text_length (text_length),
		.last_res    (last_res),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	// One output word: a character of the description, or the end word.
	typedef struct packed {
		logic [7:0] ch;
		logic       st;
		logic [7:0] len;
		logic       fin;
	} text_word_t;

	// Directed row: one script byte, plus the end word where it is obvious.
	typedef struct packed {
		logic [7:0] b;
		logic       l;
		logic       known;
		logic       st;
		logic [7:0] tlen;
	} steer_row_t;

	// Directed scripts: lone return opcode, bad first byte (0xff), push of zero,
	// 1NEGATE, OP_16, reserved opcode, short PUSHDATA1, empty PUSHDATA1,
	// one-byte push of 0xff, missing data, a byte after a complete push.
	steer_row_t steer_rows [24] = '{
		'{orf_pkg::OPC_RETURN,    1'b1, 1'b1, 1'b0, 8'd10},
		'{8'hff,                  1'b1, 1'b1, 1'b1, 8'd0},
		'{orf_pkg::OPC_RETURN,    1'b0, 1'b0, 1'b0, 8'd0},
		'{OPC_0,                  1'b1, 1'b1, 1'b0, 8'd12},
		'{orf_pkg::OPC_RETURN,    1'b0, 1'b0, 1'b0, 8'd0},
		'{orf_pkg::OPC_1NEGATE,   1'b1, 1'b1, 1'b0, 8'd13},
		'{orf_pkg::OPC_RETURN,    1'b0, 1'b0, 1'b0, 8'd0},
		'{orf_pkg::OPC_16,        1'b1, 1'b1, 1'b0, 8'd13},
		'{orf_pkg::OPC_RETURN,    1'b0, 1'b0, 1'b0, 8'd0},
		'{orf_pkg::OPC_RESERVED,  1'b1, 1'b1, 1'b1, 8'd0},
		'{orf_pkg::OPC_RETURN,    1'b0, 1'b0, 1'b0, 8'd0},
		'{orf_pkg::OPC_PUSHDATA1, 1'b1, 1'b1, 1'b1, 8'd0},
		'{orf_pkg::OPC_RETURN,    1'b0, 1'b0, 1'b0, 8'd0},
		'{orf_pkg::OPC_PUSHDATA1, 1'b0, 1'b0, 1'b0, 8'd0},
		'{8'h00,                  1'b1, 1'b1, 1'b0, 8'd11},
		'{orf_pkg::OPC_RETURN,    1'b0, 1'b0, 1'b0, 8'd0},
		'{8'h01,                  1'b0, 1'b0, 1'b0, 8'd0},
		'{8'hff,                  1'b1, 1'b1, 1'b0, 8'd15},
		'{orf_pkg::OPC_RETURN,    1'b0, 1'b0, 1'b0, 8'd0},
		'{8'h02,                  1'b0, 1'b0, 1'b0, 8'd0},
		'{8'h00,                  1'b1, 1'b1, 1'b1, 8'd0},
		'{orf_pkg::OPC_RETURN,    1'b0, 1'b0, 1'b0, 8'd0},
		'{OPC_0,                  1'b0, 1'b0, 1'b0, 8'd0},
		'{8'h00,                  1'b1, 1'b1, 1'b1, 8'd0}
	};

	// Shadow of the formatter: script state and the push length limit.
	orf_pkg::phase_t pred_phase = orf_pkg::PH_FIRST;
	logic       pred_rej = 1'b0;
	logic [8:0] pred_count = '0;
	logic [8:0] pred_expect = '0;
	logic [7:0] pred_text = '0;
	logic [7:0] push_limit = orf_pkg::MAX_PUSH_RESET;

	text_word_t text_due [$];   // words the block still owes, oldest first
	logic [7:0] script_q [$];   // script under construction
	text_word_t rx_want;

	int  errors = 0;
	int  cycles = 0;
	int  rx_wait = 0;
	int  n_bytes = 0;
	int  n_scripts = 0;
	int  n_rejects = 0;
	int  n_checked = 0;
	int  n_saturated = 0;
	bit  idle_on = 1'b1;

	function automatic int draw_wait();
		return idle_on ? $urandom_range(0, 3) : 0;
	endfunction

	function automatic void put_char(input logic [7:0] c);
		text_due.push_back('{c, 1'b0, 8'd0, 1'b0});
		if (pred_text != 8'd255) pred_text++;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		return (nib < 4'd10) ? orf_pkg::CH_ZERO + 8'(nib) : 8'h61 + 8'(nib) - 8'd10;
	endfunction

	// Expected words for one accepted script byte.
	function automatic void spell_byte(input logic [7:0] b, input logic l);
		logic [7:0] num;
		logic [8:0] total;
		num = b - orf_pkg::OPC_RESERVED;
		if (!pred_rej) begin
			case (pred_phase)
				orf_pkg::PH_FIRST: begin
					if (b == orf_pkg::OPC_RETURN) begin
						for (int i = 0; i < 9; i++) put_char(orf_pkg::OP_TEXT[i]);
						pred_phase = orf_pkg::PH_OPCODE;
					end else begin
						pred_rej = 1'b1;
					end
				end
				orf_pkg::PH_OPCODE: begin
					if (b > orf_pkg::OPC_16 || b == orf_pkg::OPC_RESERVED ||
							b == orf_pkg::OPC_PUSHDATA2 || b == orf_pkg::OPC_PUSHDATA4) begin
						pred_rej = 1'b1;
					end else if (b == OPC_0) begin
						put_char(orf_pkg::CH_SPACE);
						put_char(orf_pkg::CH_ZERO);
						pred_phase = orf_pkg::PH_DONE;
					end else if (b <= orf_pkg::DIRECT_MAX) begin
						put_char(orf_pkg::CH_SPACE);
						put_char(orf_pkg::CH_ZERO);
						put_char(orf_pkg::CH_X);
						pred_expect = 9'(b);
						pred_count = '0;
						pred_phase = orf_pkg::PH_DATA;
					end else if (b == orf_pkg::OPC_PUSHDATA1) begin
						put_char(orf_pkg::CH_SPACE);
						pred_phase = orf_pkg::PH_LEN;
					end else if (b == orf_pkg::OPC_1NEGATE) begin
						put_char(orf_pkg::CH_SPACE);
						put_char(orf_pkg::CH_MINUS);
						put_char(orf_pkg::CH_ONE);
						pred_phase = orf_pkg::PH_DONE;
					end else begin
						// OP_1 .. OP_16 as decimal
						put_char(orf_pkg::CH_SPACE);
						if (num >= 8'd10) put_char(orf_pkg::CH_ZERO + num / 8'd10);
						put_char(orf_pkg::CH_ZERO + num % 8'd10);
						pred_phase = orf_pkg::PH_DONE;
					end
				end
				orf_pkg::PH_LEN: begin
					if (b > push_limit) begin
						pred_rej = 1'b1;
					end else if (b == 8'd0) begin
						pred_expect = '0;
						pred_phase = orf_pkg::PH_DONE;
					end else begin
						put_char(orf_pkg::CH_ZERO);
						put_char(orf_pkg::CH_X);
						pred_expect = 9'(b);
						pred_count = '0;
						pred_phase = orf_pkg::PH_DATA;
					end
				end
				orf_pkg::PH_DATA: begin
					put_char(hex_digit(b[7:4]));
					put_char(hex_digit(b[3:0]));
					if (pred_count < 9'd511) pred_count++;
					if (pred_count >= pred_expect) pred_phase = orf_pkg::PH_DONE;
				end
				default: pred_rej = 1'b1;   // anything after a complete push
			endcase
		end
		if (l) begin
			if (!pred_rej && (pred_phase == orf_pkg::PH_OPCODE ||
					pred_phase == orf_pkg::PH_DONE)) begin
				total = 9'(pred_text) + 9'd1;
				if (total > 9'd255) begin
					total = 9'd255;
					n_saturated++;
				end
				text_due.push_back('{orf_pkg::CH_NUL, 1'b0, total[7:0], 1'b1});
			end else begin
				text_due.push_back('{orf_pkg::CH_NUL, 1'b1, 8'd0, 1'b1});
				n_rejects++;
			end
			pred_phase = orf_pkg::PH_FIRST;
			pred_rej = 1'b0;
			pred_count = '0;
			pred_expect = '0;
			pred_text = '0;
		end
	endfunction

	// Offer one byte after a random gap; predict once it is taken.
	task automatic send_word(input logic [7:0] b, input logic l);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		script_byte <= b;
		last <= l;
		@(posedge clk);
		while (full) @(posedge clk);
		spell_byte(b, l);
		n_bytes++;
	endtask

	task automatic send_script();
		idle_on = ($urandom_range(0, 3) != 0);
		foreach (script_q[i]) send_word(script_q[i], i == script_q.size() - 1);
		n_scripts++;
	endtask

	task automatic add_data(input int cnt);
		repeat (cnt) script_q.push_back(8'($urandom_range(0, 255)));
	endtask

	// Mostly well-formed scripts with random content; about a third broken.
	task automatic make_script();
		int kind;
		int len;
		int cap;
		logic [7:0] op;
		kind = $urandom_range(0, 99);
		cap = (push_limit < 8'd6) ? int'(push_limit) : 6;
		script_q.delete();
		script_q.push_back(orf_pkg::OPC_RETURN);
		if (kind < 8) begin
			// return opcode alone
		end else if (kind < 18) begin
			case ($urandom_range(0, 2))
				0: op = OPC_0;
				1: op = orf_pkg::OPC_1NEGATE;
				default: op = 8'($urandom_range(81, 96));
			endcase
			script_q.push_back(op);
		end else if (kind < 42) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 75) : $urandom_range(1, 6);
			script_q.push_back(8'(len));
			add_data(len);
		end else if (kind < 66) begin
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, push_limit) :
				$urandom_range(0, cap);
			script_q.push_back(orf_pkg::OPC_PUSHDATA1);
			script_q.push_back(8'(len));
			add_data(len);
		end else begin
			case ($urandom_range(0, 6))
				0: begin
					// wrong first byte
					do op = 8'($urandom_range(0, 255)); while (op == orf_pkg::OPC_RETURN);
					script_q[0] = op;
					add_data($urandom_range(0, 4));
				end
				1: begin
					case ($urandom_range(0, 3))
						0: op = orf_pkg::OPC_RESERVED;
						1: op = orf_pkg::OPC_PUSHDATA2;
						2: op = orf_pkg::OPC_PUSHDATA4;
						default: op = 8'($urandom_range(97, 255));
					endcase
					script_q.push_back(op);
					add_data($urandom_range(0, 2));
				end
				2: script_q.push_back(orf_pkg::OPC_PUSHDATA1);   // ends before the length
				3: begin
					if (push_limit != 8'd255) begin
						script_q.push_back(orf_pkg::OPC_PUSHDATA1);
						script_q.push_back(8'($urandom_range(push_limit + 1, 255)));
						add_data($urandom_range(0, 3));
					end else begin
						script_q.push_back(orf_pkg::OPC_PUSHDATA4);
					end
				end
				4: begin
					// data runs short
					len = $urandom_range(2, 8);
					script_q.push_back(8'(len));
					add_data($urandom_range(0, len - 1));
				end
				5: begin
					// surplus bytes after a complete push
					if ($urandom_range(0, 1)) begin
						script_q.push_back(OPC_0);
					end else begin
						script_q.push_back(8'd1);
						add_data(1);
					end
					add_data($urandom_range(1, 3));
				end
				default: begin
					script_q.delete();
					add_data($urandom_range(1, 6));
				end
			endcase
		end
	endtask

	// Stop offering bytes and let the back end drain before the limit changes.
	task automatic wait_drained();
		push <= 1'b0;
		while (text_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] v);
		cfg_write <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		push_limit = v;
	endtask

	// Result side: random stalls on pop, check every accepted word in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (text_due.size() == 0) begin
					$display("%0t: unexpected word, got char 0x%02h status %0d len %0d end %0d",
						$time, character, status, text_length, last_res);
					errors++;
				end else begin
					rx_want = text_due.pop_front();
					if (rx_want.ch != character) begin
						$display("%0t: character expected 0x%02h, got 0x%02h",
							$time, rx_want.ch, character);
						errors++;
					end
					if (rx_want.st != status) begin
						$display("%0t: status expected %0d, got %0d", $time, rx_want.st, status);
						errors++;
					end
					if (rx_want.len != text_length) begin
						$display("%0t: text_length expected %0d, got %0d",
							$time, rx_want.len, text_length);
						errors++;
					end
					if (rx_want.fin != last_res) begin
						$display("%0t: last_res expected %0d, got %0d",
							$time, rx_want.fin, last_res);
						errors++;
					end
					n_checked++;
				end
				rx_wait = draw_wait();
			end
			if (rx_wait > 0) begin
				pop <= 1'b0;
				rx_wait--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d words outstanding", $time, text_due.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [7:0] limits [5];
		int phase_bytes;
		limits[0] = 8'd0;
		limits[1] = 8'd1;
		limits[2] = orf_pkg::MAX_PUSH_RESET;
		limits[3] = 8'($urandom_range(2, 254));
		limits[4] = 8'd255;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table at the reset limit; the end word is typed in where known.
		foreach (steer_rows[i]) begin
			send_word(steer_rows[i].b, steer_rows[i].l);
			if (steer_rows[i].l) n_scripts++;
			if (steer_rows[i].known &&
					(text_due[$].st != steer_rows[i].st || text_due[$].len != steer_rows[i].tlen)) begin
				$display("%0t: row %0d end word expected status %0d len %0d, got status %0d len %0d",
					$time, i, steer_rows[i].st, steer_rows[i].tlen, text_due[$].st, text_due[$].len);
				errors++;
			end
		end

		// Random scripts under each limit, extremes included.
		foreach (limits[p]) begin
			wait_drained();
			write_limit(limits[p]);
			if (limits[p] == 8'd255) begin
				// longest push: text count saturates
				script_q.delete();
				script_q.push_back(orf_pkg::OPC_RETURN);
				script_q.push_back(orf_pkg::OPC_PUSHDATA1);
				script_q.push_back(8'd255);
				add_data(255);
				send_script();
			end
			phase_bytes = 0;
			while (phase_bytes < PHASE_WORDS) begin
				make_script();
				phase_bytes += script_q.size();
				send_script();
			end
		end
		push <= 1'b0;

		while (text_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (text_due.size() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, text_due.size());
			errors++;
		end
		$display("Ran %0d scripts (%0d bytes) over 5 push limits; %0d words checked.",
			n_scripts, n_bytes, n_checked);
		$display("%0d scripts rejected, %0d with saturated text length; %0d errors.",
			n_rejects, n_saturated, errors);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
